@@ hw/rtl/acpu_pkg.sv @@
// Shared types, constants and helpers for the accumulator processor block.
package acpu_pkg;

    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam logic [31:0] MEM_DEPTH_W = 32'(MEM_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [3:0] OP_HLT = 4'hE;
    localparam logic [3:0] OP_SKZ = 4'h1;
    localparam logic [3:0] OP_ADD = 4'h2;
    localparam logic [3:0] OP_SUB = 4'h3;
    localparam logic [3:0] OP_XOR = 4'h4;
    localparam logic [3:0] OP_LDA = 4'h5;
    localparam logic [3:0] OP_STA = 4'h6;
    localparam logic [3:0] OP_JMP = 4'h7;
    localparam logic [3:0] OP_JSR = 4'h8;
    localparam logic [3:0] OP_JMI = 4'h9;
    localparam logic [3:0] OP_LDI = 4'hA;
    localparam logic [3:0] OP_STI = 4'hB;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_HALT    = 3'd2;
    localparam logic [2:0] ST_BADOP   = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;
    localparam logic [2:0] ST_STOPPED = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  load_addr;
        logic [31:0] load_data;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [27:0] exec_pc;
        logic [31:0] instr_word;
        logic [31:0] acc_value;
    } out_word_t;

    typedef enum logic [2:0] {
        K_LOAD,
        K_LOAD_BAD,
        K_RESTART,
        K_STEP,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [MEM_AW-1:0]  addr;
        logic [31:0]        data;
    } q_word_t;

    function automatic logic in_range(input logic [31:0] a);
        return a < MEM_DEPTH_W;
    endfunction

endpackage

@@ hw/rtl/acpu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module acpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/acpu_front.sv @@
// Front stage: accepts request words and classifies them for the back end.
module acpu_front
    import acpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  in_word_t req_word,
    output logic     push_valid,
    input  logic     push_stall,
    output q_word_t  push_word
);

    logic        valid_reg;
    q_word_t     word_reg;
    q_word_t     word_next;
    logic [31:0] addr_ext;

    assign addr_ext = {24'b0, req_word.load_addr};

    always_comb
    begin
        word_next.addr = addr_ext[MEM_AW-1:0];
        word_next.data = req_word.load_data;
        case (req_word.cmd)
            CMD_LOAD:    word_next.kind = in_range(addr_ext) ? K_LOAD : K_LOAD_BAD;
            CMD_STEP:    word_next.kind = K_STEP;
            CMD_RESTART: word_next.kind = K_RESTART;
            default:     word_next.kind = K_NOP;
        endcase
    end

    assign req_stall  = valid_reg && push_stall;
    assign push_valid = valid_reg;
    assign push_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ hw/rtl/acpu_queue.sv @@
// Short queue of classified words between the front and back stages.
module acpu_queue
    import acpu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_stall,
    input  q_word_t push_word,
    output logic    pop_valid,
    input  logic    pop_stall,
    output q_word_t pop_word
);

    q_word_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]   wr_ptr_reg;
    logic [QUEUE_PW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;
    logic                  push;
    logic                  pop;

    assign push_stall = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    function automatic logic [QUEUE_PW-1:0] ptr_inc(input logic [QUEUE_PW-1:0] p);
        return (p == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ hw/rtl/acpu_back.sv @@
// Back stage: executes classified words against the word memory and machine state.
module acpu_back
    import acpu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_stall,
    input  q_word_t   pop_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_word_t rsp_word
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_PTR,
        S_OPER
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [27:0] pc_reg, pc_next;
    logic        stopped_reg, stopped_next;
    logic [27:0] epc_reg, epc_next;
    logic [31:0] ir_reg, ir_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_reg, out_next;

    logic              ram_we;
    logic [MEM_AW-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic [MEM_AW-1:0] ram_raddr;
    logic [31:0]       ram_rdata;

    logic        out_free;
    logic        take;
    logic        finish;
    logic [2:0]  res_status;
    logic [27:0] res_epc;
    logic [31:0] res_ir;
    logic [3:0]  f_op;
    logic [27:0] f_addr;
    logic        f_addr_ok;
    logic [3:0]  r_op;

    acpu_ram #(
        .WIDTH (32),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign pop_stall = !(state_reg == S_IDLE && out_free);
    assign take      = pop_valid && !pop_stall;
    assign f_op      = ram_rdata[31:28];
    assign f_addr    = ram_rdata[27:0];
    assign f_addr_ok = in_range({4'b0, f_addr});
    assign r_op      = ir_reg[31:28];
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        pc_next        = pc_reg;
        stopped_next   = stopped_reg;
        epc_next       = epc_reg;
        ir_next        = ir_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;
        finish         = 1'b0;
        res_status     = ST_OK;
        res_epc        = '0;
        res_ir         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (pop_word.kind)
                        K_LOAD:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pop_word.addr;
                            ram_wdata = pop_word.data;
                            finish    = 1'b1;
                        end
                        K_LOAD_BAD:
                        begin
                            res_status = ST_RANGE;
                            finish     = 1'b1;
                        end
                        K_RESTART:
                        begin
                            acc_next     = '0;
                            pc_next      = '0;
                            stopped_next = 1'b0;
                            finish       = 1'b1;
                        end
                        K_STEP:
                        begin
                            res_epc = pc_reg;
                            if (stopped_reg)
                            begin
                                res_status = ST_STOPPED;
                                finish     = 1'b1;
                            end
                            else if (!in_range({4'b0, pc_reg}))
                            begin
                                res_status   = ST_RANGE;
                                stopped_next = 1'b1;
                                finish       = 1'b1;
                            end
                            else
                            begin
                                ram_raddr  = pc_reg[MEM_AW-1:0];
                                epc_next   = pc_reg;
                                pc_next    = pc_reg + 28'd1;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                ir_next    = ram_rdata;
                res_epc    = epc_reg;
                res_ir     = ram_rdata;
                res_status = ST_EXEC;
                case (f_op)
                    OP_HLT:
                    begin
                        res_status   = ST_HALT;
                        stopped_next = 1'b1;
                        finish       = 1'b1;
                    end
                    OP_SKZ:
                    begin
                        if (acc_reg == '0)
                        begin
                            pc_next = pc_reg + 28'd1;
                        end
                        finish = 1'b1;
                    end
                    OP_JMP:
                    begin
                        pc_next = f_addr;
                        finish  = 1'b1;
                    end
                    OP_JSR:
                    begin
                        if (f_addr_ok)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = f_addr[MEM_AW-1:0];
                            ram_wdata = {4'b0, pc_reg};
                            pc_next   = f_addr + 28'd1;
                        end
                        finish = 1'b1;
                    end
                    OP_STA:
                    begin
                        if (f_addr_ok)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = f_addr[MEM_AW-1:0];
                            ram_wdata = acc_reg;
                        end
                        finish = 1'b1;
                    end
                    OP_JMI, OP_LDI, OP_STI:
                    begin
                        if (f_addr_ok)
                        begin
                            ram_raddr  = f_addr[MEM_AW-1:0];
                            state_next = S_PTR;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_XOR, OP_LDA:
                    begin
                        if (f_addr_ok)
                        begin
                            ram_raddr  = f_addr[MEM_AW-1:0];
                            state_next = S_OPER;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_status   = ST_BADOP;
                        stopped_next = 1'b1;
                        finish       = 1'b1;
                    end
                endcase
                if (!f_addr_ok && (f_op == OP_JSR || f_op == OP_STA || f_op == OP_JMI
                    || f_op == OP_LDI || f_op == OP_STI || f_op == OP_ADD
                    || f_op == OP_SUB || f_op == OP_XOR || f_op == OP_LDA))
                begin
                    res_status   = ST_RANGE;
                    stopped_next = 1'b1;
                end
            end
            S_PTR:
            begin
                res_epc    = epc_reg;
                res_ir     = ir_reg;
                res_status = ST_EXEC;
                if (r_op == OP_JMI)
                begin
                    pc_next = ram_rdata[27:0];
                    finish  = 1'b1;
                end
                else if (!in_range(ram_rdata))
                begin
                    res_status   = ST_RANGE;
                    stopped_next = 1'b1;
                    finish       = 1'b1;
                end
                else if (r_op == OP_STI)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ram_rdata[MEM_AW-1:0];
                    ram_wdata = acc_reg;
                    finish    = 1'b1;
                end
                else
                begin
                    ram_raddr  = ram_rdata[MEM_AW-1:0];
                    state_next = S_OPER;
                end
            end
            S_OPER:
            begin
                res_epc    = epc_reg;
                res_ir     = ir_reg;
                res_status = ST_EXEC;
                case (r_op)
                    OP_ADD:  acc_next = acc_reg + ram_rdata;
                    OP_SUB:  acc_next = acc_reg - ram_rdata;
                    OP_XOR:  acc_next = acc_reg ^ ram_rdata;
                    default: acc_next = ram_rdata;
                endcase
                finish = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        if (finish)
        begin
            state_next          = S_IDLE;
            out_valid_next      = 1'b1;
            out_next.status     = res_status;
            out_next.exec_pc    = res_epc;
            out_next.instr_word = res_ir;
            out_next.acc_value  = acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            epc_reg       <= '0;
            ir_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pc_reg        <= pc_next;
            stopped_reg   <= stopped_next;
            epc_reg       <= epc_next;
            ir_reg        <= ir_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

@@ hw/rtl/accumulator_cpu_step.sv @@
// Top level of the accumulator processor: front stage, word queue and execution back end.
//
//   Channel   Direction   Handshake             Word type
//   req       in          req_valid/req_stall   in_word_t
//   rsp       out         rsp_valid/rsp_stall   out_word_t
//
// Load, restart and stopped or out-of-range step words finish in the idle state; an
// executed step uses fetch and, as needed, pointer and operand states, one per dependent
// read of the single word memory read port. Front register and queue add latency but
// not occupancy. Reset clears the machine state and all handshake control; memory
// contents are undefined until loaded, so there is no clearing pass.
// A stalled response holds its word while the front keeps filling the queue.
module accumulator_cpu_step
    import acpu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  in_word_t  req_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_word_t rsp_word
);

    logic    fq_valid;
    logic    fq_stall;
    q_word_t fq_word;
    logic    qb_valid;
    logic    qb_stall;
    q_word_t qb_word;

    acpu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_word   (req_word),
        .push_valid (fq_valid),
        .push_stall (fq_stall),
        .push_word  (fq_word)
    );

    acpu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_stall (fq_stall),
        .push_word  (fq_word),
        .pop_valid  (qb_valid),
        .pop_stall  (qb_stall),
        .pop_word   (qb_word)
    );

    acpu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (qb_valid),
        .pop_stall (qb_stall),
        .pop_word  (qb_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule
